### rtl/pa_pkg.sv
// shared types and codes for the process identifier allocator
// used by pa_scan_unit and pid_allocator_next_safe; depends on nothing
package pa_pkg;

	// fixed field widths of the transaction ports
	localparam int ID_FIELD_W = 10;
	localparam int STATUS_W   = 2;

	// command codes
	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_LIVE = 2'd2;

	// sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	// per-entry outcome of the scan unit
	typedef struct packed {
		logic restart;
		logic free;
		logic hit;
	} scan_flags_t;

endpackage

### rtl/pa_scan_unit.sv
// shared compare unit: evaluates one table entry against the candidate,
// the safe bound and the release identifier; depends on pa_pkg
module pa_scan_unit #(
	parameter int PID_LIMIT = 1024
) (
	input  logic                                 alloc,
	input  logic                                 pick,
	input  logic                                 ent_valid,
	input  logic [$clog2(PID_LIMIT)-1:0]         ent_id,
	input  logic [pa_pkg::ID_FIELD_W-1:0]        rel_id,
	input  logic [$clog2(PID_LIMIT+1)-1:0]       cand,
	input  logic [$clog2(PID_LIMIT+1)-1:0]       bound,
	input  logic                                 free_found,
	input  logic                                 hit_found,
	output logic [$clog2(PID_LIMIT+1)-1:0]       cand_nxt,
	output logic [$clog2(PID_LIMIT+1)-1:0]       bound_nxt,
	output pa_pkg::scan_flags_t                  flags
);

	localparam int IDW  = $clog2(PID_LIMIT);
	localparam int BW   = $clog2(PID_LIMIT+1);
	localparam int RW   = pa_pkg::ID_FIELD_W;
	localparam int CMPW = (IDW > RW) ? IDW : RW;

	logic [BW:0]   cand_inc;
	logic [BW:0]   limit_w;
	logic [BW:0]   bound_w;
	logic [BW-1:0] id_ext;
	logic          coll;

	assign cand_inc = {1'b0, cand} + {{BW{1'b0}}, 1'b1};
	assign limit_w  = (BW+1)'(PID_LIMIT);
	assign bound_w  = {1'b0, bound};
	assign id_ext   = BW'(ent_id);
	assign coll     = pick && ent_valid && (id_ext == cand);

	// candidate bump, rescan on reaching the bound, bound shrink
	always_comb begin
		cand_nxt      = cand;
		bound_nxt     = bound;
		flags.restart = 1'b0;
		// lowest free slot on allocate, first matching live slot on release
		flags.free    = alloc && !ent_valid && !free_found;
		flags.hit     = !alloc && ent_valid && !hit_found &&
			(CMPW'(ent_id) == CMPW'(rel_id));
		if (coll) begin
			if (cand_inc >= bound_w) begin
				flags.restart = 1'b1;
				bound_nxt     = BW'(PID_LIMIT);
				if (cand_inc >= limit_w) begin
					cand_nxt = BW'(1);
				end else begin
					cand_nxt = BW'(cand_inc);
				end
			end else begin
				cand_nxt = BW'(cand_inc);
			end
		end else if (pick && ent_valid && (id_ext > cand) && (bound > id_ext)) begin
			bound_nxt = id_ext;
		end
	end

endmodule

### rtl/pid_allocator_next_safe.sv
// top level of the process identifier allocator: sequencer, live table
// memory and state registers; depends on pa_pkg and pa_scan_unit
//
// Hands out identifiers 1..PID_LIMIT-1 (never 0) and takes them back on
// release. A transaction is accepted when start is high and busy is low; its
// single result appears on status and given_id for exactly one cycle with
// done high, and the receiver cannot stall it. Every transaction but an
// allocate on a full table walks the live table through one read port and
// one shared compare unit, one entry a cycle, and an allocate whose candidate
// collides at the safe bound starts another pass. An allocate on a full table
// skips the walk and goes straight to commit. After reset the table is
// cleared one entry a cycle, and busy stays high until the clearing ends.
module pid_allocator_next_safe #(
	parameter int PID_LIMIT   = 1024,
	parameter int TABLE_DEPTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 command,
	input  logic [pa_pkg::ID_FIELD_W-1:0]        release_id,
	output logic                                 done,
	output logic [pa_pkg::STATUS_W-1:0]          status,
	output logic [pa_pkg::ID_FIELD_W-1:0]        given_id
);

	localparam int IDW = $clog2(PID_LIMIT);
	localparam int BW  = $clog2(PID_LIMIT+1);
	localparam int AW  = $clog2(TABLE_DEPTH);
	localparam int CW  = $clog2(TABLE_DEPTH+1);
	localparam int FW  = pa_pkg::ID_FIELD_W;
	localparam int SW  = pa_pkg::STATUS_W;
	localparam int MW  = IDW + 1;

	pa_pkg::state_t state_q, state_d;

	// live table: valid bit over identifier
	logic [MW-1:0] mem [TABLE_DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [MW-1:0] mem_wdata;

	logic [AW-1:0] clr_idx_q;
	logic          cmd_q;
	logic [FW-1:0] rel_q;
	logic          full_q;
	logic          pick_q;
	logic [BW-1:0] cand_q;
	logic [BW-1:0] bound_q;
	logic [BW-1:0] last_q;
	logic [CW-1:0] count_q;
	logic          free_found_q;
	logic [AW-1:0] free_slot_q;
	logic          hit_found_q;
	logic [AW-1:0] hit_slot_q;
	logic [CW-1:0] rd_idx_q;
	logic          vld_s1;
	logic [AW-1:0] idx_s1;
	logic [MW-1:0] rdata_s1;
	logic          done_q;
	logic [SW-1:0] status_q;
	logic [FW-1:0] given_q;

	logic          accept;
	logic          is_alloc;
	logic          full_now;
	logic [BW:0]   last_inc;
	logic [BW-1:0] init_cand;
	logic          init_pick;
	logic          rd_issue;
	logic          scan_done;
	logic          alloc_ok;
	logic          release_ok;
	logic [BW-1:0] cand_nxt;
	logic [BW-1:0] bound_nxt;
	pa_pkg::scan_flags_t flags;

	assign busy     = (state_q != pa_pkg::ST_IDLE);
	assign accept   = start && (state_q == pa_pkg::ST_IDLE);
	assign is_alloc = (cmd_q == pa_pkg::CMD_ALLOC);

	// full when the table or the identifier space is used up
	assign full_now = (32'(count_q) >= 32'(TABLE_DEPTH)) ||
		(32'(count_q) >= 32'(PID_LIMIT - 1));

	// first candidate and whether the table must be scanned for it
	assign last_inc = {1'b0, last_q} + {{BW{1'b0}}, 1'b1};
	always_comb begin
		if (last_inc >= (BW+1)'(PID_LIMIT)) begin
			init_cand = BW'(1);
			init_pick = 1'b1;
		end else begin
			init_cand = BW'(last_inc);
			init_pick = (last_inc >= {1'b0, bound_q});
		end
	end

	// shared entry compare unit
	pa_scan_unit #(
		.PID_LIMIT (PID_LIMIT)
	) u_scan (
		.alloc      (is_alloc),
		.pick       (pick_q && is_alloc && vld_s1),
		.ent_valid  (rdata_s1[MW-1]),
		.ent_id     (rdata_s1[IDW-1:0]),
		.rel_id     (rel_q),
		.cand       (cand_q),
		.bound      (bound_q),
		.free_found (free_found_q),
		.hit_found  (hit_found_q),
		.cand_nxt   (cand_nxt),
		.bound_nxt  (bound_nxt),
		.flags      (flags)
	);

	assign rd_issue  = (state_q == pa_pkg::ST_SCAN) && (rd_idx_q < CW'(TABLE_DEPTH));
	assign scan_done = vld_s1 && (idx_s1 == AW'(TABLE_DEPTH - 1)) && !flags.restart;
	assign alloc_ok  = is_alloc && !full_q;
	assign release_ok = !is_alloc && hit_found_q && (rel_q != '0);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pa_pkg::ST_CLEAR: begin
				if (clr_idx_q == AW'(TABLE_DEPTH - 1)) begin
					state_d = pa_pkg::ST_IDLE;
				end
			end
			pa_pkg::ST_IDLE: begin
				if (accept) begin
					if ((command == pa_pkg::CMD_ALLOC) && full_now) begin
						state_d = pa_pkg::ST_COMMIT;
					end else begin
						state_d = pa_pkg::ST_SCAN;
					end
				end
			end
			pa_pkg::ST_SCAN: begin
				if (scan_done) begin
					state_d = pa_pkg::ST_COMMIT;
				end
			end
			pa_pkg::ST_COMMIT: begin
				state_d = pa_pkg::ST_IDLE;
			end
			default: begin
				state_d = pa_pkg::ST_IDLE;
			end
		endcase
	end

	// table write port per state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_idx_q;
		mem_wdata = '0;
		case (state_q)
			pa_pkg::ST_CLEAR: begin
				mem_we = 1'b1;
			end
			pa_pkg::ST_COMMIT: begin
				if (alloc_ok) begin
					mem_we    = 1'b1;
					mem_waddr = free_slot_q;
					mem_wdata = {1'b1, IDW'(cand_q)};
				end else if (release_ok) begin
					mem_we    = 1'b1;
					mem_waddr = hit_slot_q;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// table memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			rdata_s1 <= mem[rd_idx_q[AW-1:0]];
			idx_s1   <= rd_idx_q[AW-1:0];
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (state_q == pa_pkg::ST_CLEAR) begin
			clr_idx_q <= clr_idx_q + AW'(1);
		end
	end

	// scan read pointer; a restart drops the read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
		end else if (accept || (vld_s1 && flags.restart)) begin
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
		end else if (rd_issue) begin
			rd_idx_q <= rd_idx_q + CW'(1);
			vld_s1   <= 1'b1;
		end else begin
			vld_s1   <= 1'b0;
		end
	end

	// transaction state: candidate, bound, slot search
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q        <= pa_pkg::CMD_ALLOC;
			rel_q        <= '0;
			full_q       <= 1'b0;
			pick_q       <= 1'b0;
			cand_q       <= '0;
			bound_q      <= BW'(PID_LIMIT);
			last_q       <= BW'(PID_LIMIT);
			count_q      <= '0;
			free_found_q <= 1'b0;
			free_slot_q  <= '0;
			hit_found_q  <= 1'b0;
			hit_slot_q   <= '0;
		end else begin
			if (accept) begin
				cmd_q        <= command;
				rel_q        <= release_id;
				full_q       <= full_now;
				free_found_q <= 1'b0;
				hit_found_q  <= 1'b0;
				pick_q       <= 1'b0;
				if ((command == pa_pkg::CMD_ALLOC) && !full_now) begin
					cand_q <= init_cand;
					pick_q <= init_pick;
					if (init_pick) begin
						bound_q <= BW'(PID_LIMIT);
					end
				end
			end else if ((state_q == pa_pkg::ST_SCAN) && vld_s1) begin
				cand_q  <= cand_nxt;
				bound_q <= bound_nxt;
				if (flags.free) begin
					free_found_q <= 1'b1;
					free_slot_q  <= idx_s1;
				end
				if (flags.hit) begin
					hit_found_q <= 1'b1;
					hit_slot_q  <= idx_s1;
				end
			end else if (state_q == pa_pkg::ST_COMMIT) begin
				if (alloc_ok) begin
					last_q  <= cand_q;
					count_q <= count_q + CW'(1);
				end else if (release_ok) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// result strobe and fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= 1'b0;
			status_q <= pa_pkg::STATUS_OK;
			given_q  <= '0;
		end else begin
			done_q <= (state_q == pa_pkg::ST_COMMIT);
			if (state_q == pa_pkg::ST_COMMIT) begin
				if (is_alloc) begin
					status_q <= full_q ? pa_pkg::STATUS_FULL : pa_pkg::STATUS_OK;
					given_q  <= full_q ? '0 : FW'(cand_q);
				end else begin
					status_q <= release_ok ? pa_pkg::STATUS_OK : pa_pkg::STATUS_NOT_LIVE;
					given_q  <= '0;
				end
			end
		end
	end

	assign done     = done_q;
	assign status   = status_q;
	assign given_id = given_q;

endmodule
